[rtl/core/assert_macros.svh]
// Assertion macros shared by the core RTL.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/aabb_pkg.sv]
// Widths, reset values, register indexes, types and a saturating helper for the box transform.
// Depends on nothing.
package aabb_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int COEF_WIDTH   = 16;
	localparam int COEF_FRAC    = COEF_WIDTH - 4;
	localparam int ROW_WIDTH    = 3 * COEF_WIDTH;
	localparam int PROD_WIDTH   = COORD_WIDTH + COEF_WIDTH;
	localparam int SCALED_WIDTH = PROD_WIDTH - COEF_FRAC;
	localparam int SUM_WIDTH    = SCALED_WIDTH + 2;
	localparam int CFG_WIDTH    = ROW_WIDTH > COORD_WIDTH ? ROW_WIDTH : COORD_WIDTH;
	localparam int INDEX_WIDTH  = 3;

	localparam logic [ROW_WIDTH-1:0] COEF_ONE    = ROW_WIDTH'(1) << COEF_FRAC;
	localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = COEF_ONE;
	localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = COEF_ONE << COEF_WIDTH;
	localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET = COEF_ONE << (2 * COEF_WIDTH);

	typedef enum logic [INDEX_WIDTH-1:0] {
		REG_ROW_X = 3'd0,
		REG_ROW_Y = 3'd1,
		REG_ROW_Z = 3'd2,
		REG_OFF_X = 3'd3,
		REG_OFF_Y = 3'd4,
		REG_OFF_Z = 3'd5
	} reg_index_t;

	typedef logic signed [COORD_WIDTH-1:0]  coord_t;
	typedef logic signed [SCALED_WIDTH-1:0] scaled_t;
	typedef logic signed [SUM_WIDTH-1:0]    sum_t;

	function automatic coord_t saturate(input sum_t s);
		coord_t r;
		if (s > sum_t'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}})))
			r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		else if (s < sum_t'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}})))
			r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		else
			r = s[COORD_WIDTH-1:0];
		return r;
	endfunction

endpackage

[rtl/core/aabb_affine_transform.sv]
// Affine transform of an axis-aligned box, bounding the eight mapped corners.
// Depends on aabb_pkg and assert_macros.svh.
//
// Usage:
//   Raise start with the source box on in_min_* / in_max_* (signed Q16.16).
//   busy is always low, so a box is taken at every edge at which start is high.
//   Exactly one result word per box appears on out_min_* / out_max_* with done
//   high for one cycle, once the box has passed all register stages. One box
//   per cycle is sustained: five register stages (input, scaled products,
//   per-term min/max, sum, saturate) each hold a different box.
//   The matrix sits in six registers written through cfg_we / cfg_index /
//   cfg_data: three Q4.12 rows, then three Q16.16 offsets. Write them only
//   while no box is in flight; indexes beyond five are ignored.
//   Each output bound is the sum over input axes of the smaller (or larger)
//   scaled product of the two source bounds, plus the offset, saturated to
//   32 bits; this equals the bound over all eight mapped corners.
//   Reset loads the identity matrix with zero offsets and empties the pipeline.
//   The receiver cannot stall: done words must be taken as they appear.
`include "assert_macros.svh"

module aabb_affine_transform
	import aabb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  coord_t                 in_min_x,
	input  coord_t                 in_min_y,
	input  coord_t                 in_min_z,
	input  coord_t                 in_max_x,
	input  coord_t                 in_max_y,
	input  coord_t                 in_max_z,
	input  logic                   cfg_we,
	input  logic [INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]   cfg_data,
	output logic                   done,
	output coord_t                 out_min_x,
	output coord_t                 out_min_y,
	output coord_t                 out_min_z,
	output coord_t                 out_max_x,
	output coord_t                 out_max_y,
	output coord_t                 out_max_z
);

	logic [ROW_WIDTH-1:0] row_q [3];
	coord_t               off_q [3];

	logic   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	coord_t lo_s1 [3];
	coord_t hi_s1 [3];
	scaled_t plo_s2 [3][3];
	scaled_t phi_s2 [3][3];
	scaled_t mn_s3 [3][3];
	scaled_t mx_s3 [3][3];
	sum_t   smin_s4 [3];
	sum_t   smax_s4 [3];
	coord_t bmin_s5 [3];
	coord_t bmax_s5 [3];

	logic signed [PROD_WIDTH-1:0] prod_lo [3][3];
	logic signed [PROD_WIDTH-1:0] prod_hi [3][3];
	logic signed [COEF_WIDTH-1:0] coef    [3][3];

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW_X_RESET;
			row_q[1] <= ROW_Y_RESET;
			row_q[2] <= ROW_Z_RESET;
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ROW_X: row_q[0] <= cfg_data[ROW_WIDTH-1:0];
				REG_ROW_Y: row_q[1] <= cfg_data[ROW_WIDTH-1:0];
				REG_ROW_Z: row_q[2] <= cfg_data[ROW_WIDTH-1:0];
				REG_OFF_X: off_q[0] <= cfg_data[COORD_WIDTH-1:0];
				REG_OFF_Y: off_q[1] <= cfg_data[COORD_WIDTH-1:0];
				REG_OFF_Z: off_q[2] <= cfg_data[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: hold the source box
	always_ff @(posedge clk) begin
		lo_s1[0] <= in_min_x;
		lo_s1[1] <= in_min_y;
		lo_s1[2] <= in_min_z;
		hi_s1[0] <= in_max_x;
		hi_s1[1] <= in_max_y;
		hi_s1[2] <= in_max_z;
	end

	// stage 2: scaled products, floor(coef * coord / 2^COEF_FRAC)
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				coef[j][k]    = row_q[j][k*COEF_WIDTH +: COEF_WIDTH];
				prod_lo[j][k] = lo_s1[k] * coef[j][k];
				prod_hi[j][k] = hi_s1[k] * coef[j][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				plo_s2[j][k] <= prod_lo[j][k][PROD_WIDTH-1:COEF_FRAC];
				phi_s2[j][k] <= prod_hi[j][k][PROD_WIDTH-1:COEF_FRAC];
			end
		end
	end

	// stage 3: per-term extremes
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				if (plo_s2[j][k] < phi_s2[j][k]) begin
					mn_s3[j][k] <= plo_s2[j][k];
					mx_s3[j][k] <= phi_s2[j][k];
				end else begin
					mn_s3[j][k] <= phi_s2[j][k];
					mx_s3[j][k] <= plo_s2[j][k];
				end
			end
		end
	end

	// stage 4: add terms and offset
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			smin_s4[j] <= sum_t'(off_q[j]) + sum_t'(mn_s3[j][0])
				+ sum_t'(mn_s3[j][1]) + sum_t'(mn_s3[j][2]);
			smax_s4[j] <= sum_t'(off_q[j]) + sum_t'(mx_s3[j][0])
				+ sum_t'(mx_s3[j][1]) + sum_t'(mx_s3[j][2]);
		end
	end

	// stage 5: saturate into the output word
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			bmin_s5[j] <= saturate(smin_s4[j]);
			bmax_s5[j] <= saturate(smax_s4[j]);
		end
	end

	assign done      = valid_s5;
	assign out_min_x = bmin_s5[0];
	assign out_min_y = bmin_s5[1];
	assign out_min_z = bmin_s5[2];
	assign out_max_x = bmax_s5[0];
	assign out_max_y = bmax_s5[1];
	assign out_max_z = bmax_s5[2];

	`ASSERT_CLK(a_latency, clk, arst_n, start |-> ##5 done, "box lost in pipeline")
	`ASSERT_CLK(a_order_x, clk, arst_n, done |-> out_min_x <= out_max_x, "x bounds inverted")
	`ASSERT_CLK(a_order_y, clk, arst_n, done |-> out_min_y <= out_max_y, "y bounds inverted")
	`ASSERT_CLK(a_order_z, clk, arst_n, done |-> out_min_z <= out_max_z, "z bounds inverted")
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !done, "done during reset")

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for aabb_affine_transform: boxes under several matrix settings,
// each result checked against a bound computed over the eight mapped corners.
// Depends on aabb_pkg and the aabb_affine_transform RTL.
module testbench;
	import aabb_pkg::*;

	typedef struct packed {
		coord_t [2:0] lo;
		coord_t [2:0] hi;
	} box_t;

	typedef enum int {
		SET_RANDOM,
		SET_MAX,
		SET_MIN,
		SET_ZERO_MATRIX,
		SET_SMALL,
		SET_MIXED,
		SET_IDENTITY
	} matrix_setting_t;

	localparam logic [INDEX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [INDEX_WIDTH-1:0] REG_SPARE_7 = 3'd7;
	localparam longint SAT_HI = 2147483647;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam int BOXES_PER_SETTING = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	coord_t in_min_x = '0;
	coord_t in_min_y = '0;
	coord_t in_min_z = '0;
	coord_t in_max_x = '0;
	coord_t in_max_y = '0;
	coord_t in_max_z = '0;
	logic cfg_we = 1'b0;
	logic [INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0] cfg_data = '0;
	logic done;
	coord_t out_min_x;
	coord_t out_min_y;
	coord_t out_min_z;
	coord_t out_max_x;
	coord_t out_max_y;
	coord_t out_max_z;

	logic [ROW_WIDTH-1:0] mat_row[3];
	coord_t mat_off[3];
	box_t box_queue[$];
	box_t pending_bounds[$];
	box_t driven_box;
	int idle_left = 0;
	bit steady_run = 1'b0;
	int boxes_taken = 0;
	int bounds_checked = 0;
	int mismatch_count = 0;
	int settings_used = 1;
	string axis_name[3] = '{"x", "y", "z"};

	aabb_affine_transform u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_min_x(in_min_x),
		.in_min_y(in_min_y),
		.in_min_z(in_min_z),
		.in_max_x(in_max_x),
		.in_max_y(in_max_y),
		.in_max_z(in_max_z),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.out_min_x(out_min_x),
		.out_min_y(out_min_y),
		.out_min_z(out_min_z),
		.out_max_x(out_max_x),
		.out_max_y(out_max_y),
		.out_max_z(out_max_z)
	);

	always #5 clk = ~clk;

	function automatic box_t bound_mapped_box(input box_t b);
		longint corner[3];
		longint acc;
		longint lo_b[3];
		longint hi_b[3];
		box_t r;
		for (int c = 0; c < 8; c++) begin
			for (int k = 0; k < 3; k++)
				corner[k] = c[k] ? longint'($signed(b.hi[k])) : longint'($signed(b.lo[k]));
			for (int a = 0; a < 3; a++) begin
				acc = longint'(mat_off[a]);
				for (int k = 0; k < 3; k++)
					acc += (longint'($signed(mat_row[a][k*COEF_WIDTH +: COEF_WIDTH]))
						* corner[k]) >>> COEF_FRAC;
				if (acc > SAT_HI)
					acc = SAT_HI;
				else if (acc < SAT_LO)
					acc = SAT_LO;
				if (c == 0 || acc < lo_b[a])
					lo_b[a] = acc;
				if (c == 0 || acc > hi_b[a])
					hi_b[a] = acc;
			end
		end
		for (int a = 0; a < 3; a++) begin
			r.lo[a] = coord_t'(lo_b[a]);
			r.hi[a] = coord_t'(hi_b[a]);
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			6, 7: return coord_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [COEF_WIDTH-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return '0;
			3: return 16'h1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_box(input coord_t ax, ay, az, bx, by, bz);
		box_t b;
		b.lo[0] = ax;
		b.lo[1] = ay;
		b.lo[2] = az;
		b.hi[0] = bx;
		b.hi[1] = by;
		b.hi[2] = bz;
		box_queue.push_back(b);
	endtask

	task automatic queue_random_box();
		box_t b;
		coord_t lo_v;
		coord_t hi_v;
		coord_t t;
		int shape;
		shape = $urandom_range(0, 15);
		for (int k = 0; k < 3; k++) begin
			lo_v = rand_coord();
			hi_v = rand_coord();
			if (shape != 1 && lo_v > hi_v) begin
				t = lo_v;
				lo_v = hi_v;
				hi_v = t;
			end
			b.lo[k] = (shape == 0) ? coord_t'(0) : lo_v;
			b.hi[k] = (shape == 0) ? coord_t'(0) : hi_v;
		end
		box_queue.push_back(b);
	endtask

	task automatic queue_extreme_boxes();
		queue_box(0, 0, 0, 0, 0, 0);
		queue_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_box(32'h0001_0000, -32'sh0002_0000, 32'h0000_8000,
			-32'sh0001_0000, 32'h0003_0000, -32'sh0000_8000);
		queue_box(-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		queue_box(32'h8000_0000, 0, 32'h0000_0001, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF);
	endtask

	task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ROW_X: mat_row[0] = data[ROW_WIDTH-1:0];
			REG_ROW_Y: mat_row[1] = data[ROW_WIDTH-1:0];
			REG_ROW_Z: mat_row[2] = data[ROW_WIDTH-1:0];
			REG_OFF_X: mat_off[0] = data[COORD_WIDTH-1:0];
			REG_OFF_Y: mat_off[1] = data[COORD_WIDTH-1:0];
			REG_OFF_Z: mat_off[2] = data[COORD_WIDTH-1:0];
			default: ;
		endcase
	endtask

	task automatic configure_matrix(input matrix_setting_t setting);
		logic [ROW_WIDTH-1:0] row[3];
		logic [COORD_WIDTH-1:0] off[3];
		int v;
		for (int a = 0; a < 3; a++) begin
			case (setting)
				SET_RANDOM: begin
					row[a] = ROW_WIDTH'({$urandom, $urandom});
					off[a] = $urandom;
				end
				SET_MAX: begin
					row[a] = {3{16'h7FFF}};
					off[a] = 32'h7FFF_FFFF;
				end
				SET_MIN: begin
					row[a] = {3{16'h8000}};
					off[a] = 32'h8000_0000;
				end
				SET_ZERO_MATRIX: begin
					row[a] = '0;
					off[a] = $urandom;
				end
				SET_SMALL: begin
					for (int k = 0; k < 3; k++) begin
						v = int'($urandom_range(0, 8192)) - 4096;
						row[a][k*COEF_WIDTH +: COEF_WIDTH] = v[COEF_WIDTH-1:0];
					end
					v = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
					off[a] = v;
				end
				SET_MIXED: begin
					row[a] = {pick_coef(), pick_coef(), pick_coef()};
					off[a] = rand_coord();
				end
				default: begin
					row[a] = (a == 0) ? ROW_X_RESET : (a == 1) ? ROW_Y_RESET : ROW_Z_RESET;
					off[a] = '0;
				end
			endcase
		end
		write_reg(REG_ROW_X, row[0]);
		write_reg(REG_ROW_Y, row[1]);
		write_reg(REG_ROW_Z, row[2]);
		// upper data bits are junk for the offsets and must be dropped
		write_reg(REG_OFF_X, CFG_WIDTH'({$urandom, off[0]}));
		write_reg(REG_OFF_Y, CFG_WIDTH'({$urandom, off[1]}));
		write_reg(REG_OFF_Z, CFG_WIDTH'({$urandom, off[2]}));
		if (setting == SET_RANDOM || setting == SET_IDENTITY) begin
			write_reg(REG_SPARE_6, CFG_WIDTH'({$urandom, $urandom}));
			write_reg(REG_SPARE_7, CFG_WIDTH'({$urandom, $urandom}));
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (box_queue.size() != 0 || start || pending_bounds.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// driver: hold a word until taken, then advance after a random gap (none in steady runs)
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				pending_bounds.push_back(bound_mapped_box(driven_box));
				boxes_taken++;
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (box_queue.size() > 0) begin
					driven_box = box_queue.pop_front();
					in_min_x <= driven_box.lo[0];
					in_min_y <= driven_box.lo[1];
					in_min_z <= driven_box.lo[2];
					in_max_x <= driven_box.hi[0];
					in_max_y <= driven_box.hi[1];
					in_max_z <= driven_box.hi[2];
					start <= 1'b1;
					idle_left = steady_run ? 0 : pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every done word is checked against the oldest expected bound
	always @(posedge clk) begin
		box_t got;
		box_t want;
		if (arst_n && done) begin
			got.lo[0] = out_min_x;
			got.lo[1] = out_min_y;
			got.lo[2] = out_min_z;
			got.hi[0] = out_max_x;
			got.hi[1] = out_max_y;
			got.hi[2] = out_max_z;
			if (pending_bounds.size() == 0) begin
				$display("%0t: unexpected result word, min x %0d max x %0d",
					$time, got.lo[0], got.hi[0]);
				mismatch_count++;
			end else begin
				want = pending_bounds.pop_front();
				bounds_checked++;
				for (int k = 0; k < 3; k++) begin
					if (got.lo[k] !== want.lo[k]) begin
						$display("%0t: out_min_%s expected %0d actual %0d", $time,
							axis_name[k], $signed(want.lo[k]), $signed(got.lo[k]));
						mismatch_count++;
					end
					if (got.hi[k] !== want.hi[k]) begin
						$display("%0t: out_max_%s expected %0d actual %0d", $time,
							axis_name[k], $signed(want.hi[k]), $signed(got.hi[k]));
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		mat_row[0] = ROW_X_RESET;
		mat_row[1] = ROW_Y_RESET;
		mat_row[2] = ROW_Z_RESET;
		for (int a = 0; a < 3; a++)
			mat_off[a] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		queue_extreme_boxes();
		for (int s = SET_RANDOM; s <= SET_IDENTITY; s++) begin
			wait_drained();
			configure_matrix(matrix_setting_t'(s));
			steady_run = (s == SET_MIN || s == SET_MIXED);
			if (s == SET_MAX)
				queue_extreme_boxes();
			repeat (BOXES_PER_SETTING)
				queue_random_box();
		end
		wait_drained();
		repeat (10) @(posedge clk);
		$display("Checked %0d of %0d boxes over %0d matrix settings,", bounds_checked,
			boxes_taken, settings_used);
		$display("including reset values, saturating extremes and ignored register writes.");
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding", pending_bounds.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/aabb_pkg.sv
rtl/core/aabb_affine_transform.sv
tb/testbench.sv
